/* sv/msk_pkg.sv */
`timescale 1ns / 1ps

package msk_pkg;

  localparam int unsigned SK_DEPTH = 1024;
  localparam int unsigned SK_AW = (SK_DEPTH > 1) ? $clog2(SK_DEPTH) : 1;
  localparam int unsigned SK_CW = $clog2(SK_DEPTH + 1);
  localparam int unsigned SK_DW = 32;

  localparam logic MODE_PUSH = 1'b0;
  localparam logic MODE_POP  = 1'b1;

  typedef enum logic [1:0] {
    ERR_OK    = 2'd0,
    ERR_EMPTY = 2'd1,
    ERR_FULL  = 2'd2
  } msk_err_e;

  typedef struct packed {
    logic                     mode;
    logic signed [SK_DW-1:0]  value;
  } msk_in_t;

  typedef struct packed {
    logic signed [SK_DW-1:0]  popped_value;
    logic signed [SK_DW-1:0]  current_min;
    logic                     min_valid;
    logic        [SK_CW-1:0]  entry_count;
    msk_err_e                 error_code;
  } msk_out_t;

endpackage

/* sv/min_stack_constant_time_top.sv */
`timescale 1ns / 1ps

// Bounded stack of signed 32-bit values that reports its minimum with every item.
// Each stored entry is kept in one RAM together with the running minimum at its
// depth, and the top entry is also cached in registers. A push, a pop of the last
// entry and any rejected operation give their result in the cycle after the item
// is accepted, so such items can be taken every cycle while the output is drained.
// A pop that leaves entries behind goes through the ST_POP state, because the new
// top entry must be read back from the RAM, whose read data is registered. Results
// wait in an output register, and the next item is taken while it is being drained.

module min_stack_constant_time_top (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  msk_pkg::msk_in_t in_item_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output msk_pkg::msk_out_t out_item_o
);

  import msk_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_POP,
    ST_HOLD
  } state_e;

  state_e                   state_q;
  logic                     out_valid_q;
  logic                     out_valid_d;
  msk_out_t                 out_q;
  logic        [SK_CW-1:0]  count_q;
  logic signed [SK_DW-1:0]  top_val_q;
  logic signed [SK_DW-1:0]  top_min_q;
  logic signed [SK_DW-1:0]  pop_val_q;

  logic                     in_fire;
  logic                     slot_free;
  logic                     is_push;
  logic                     full;
  logic                     empty;
  logic signed [SK_DW-1:0]  push_min;
  logic                     ram_we;
  logic        [SK_AW-1:0]  ram_waddr;
  logic        [SK_AW-1:0]  ram_raddr;
  logic        [SK_CW-1:0]  count_minus2;
  logic        [2*SK_DW-1:0] ram_wdata;
  logic        [2*SK_DW-1:0] ram_rdata;
  logic signed [SK_DW-1:0]  rd_val;
  logic signed [SK_DW-1:0]  rd_min;

  assign slot_free   = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == ST_IDLE) && slot_free;
  assign in_fire     = in_valid_i && in_ready_o;
  assign is_push     = (in_item_i.mode == MODE_PUSH);
  assign full        = (count_q == SK_CW'(SK_DEPTH));
  assign empty       = (count_q == '0);
  assign push_min    = (!empty && (top_min_q <= in_item_i.value)) ? top_min_q
                                                                   : in_item_i.value;

  assign ram_we       = in_fire && is_push && !full;
  assign ram_waddr    = count_q[SK_AW-1:0];
  assign ram_wdata    = {in_item_i.value, push_min};
  assign count_minus2 = count_q - SK_CW'(2);
  assign ram_raddr    = count_minus2[SK_AW-1:0];
  assign rd_val       = ram_rdata[2*SK_DW-1:SK_DW];
  assign rd_min       = ram_rdata[SK_DW-1:0];

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      ST_IDLE: begin
        if (in_fire && (is_push || empty || (count_q == SK_CW'(1)))) begin
          out_valid_d = 1'b1;
        end
      end
      ST_POP, ST_HOLD: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
        end
      end
      default: begin
        out_valid_d = out_valid_q && !out_ready_i;
      end
    endcase
  end

  msk_ram #(
    .WIDTH (2 * SK_DW),
    .DEPTH (SK_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      out_q       <= '0;
      count_q     <= '0;
      top_val_q   <= '0;
      top_min_q   <= '0;
      pop_val_q   <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            if (is_push) begin
              if (full) begin
                out_q.popped_value <= '0;
                out_q.current_min  <= top_min_q;
                out_q.min_valid    <= 1'b1;
                out_q.entry_count  <= count_q;
                out_q.error_code   <= ERR_FULL;
              end else begin
                top_val_q          <= in_item_i.value;
                top_min_q          <= push_min;
                count_q            <= count_q + SK_CW'(1);
                out_q.popped_value <= '0;
                out_q.current_min  <= push_min;
                out_q.min_valid    <= 1'b1;
                out_q.entry_count  <= count_q + SK_CW'(1);
                out_q.error_code   <= ERR_OK;
              end
            end else if (empty) begin
              out_q.popped_value <= '0;
              out_q.current_min  <= '0;
              out_q.min_valid    <= 1'b0;
              out_q.entry_count  <= '0;
              out_q.error_code   <= ERR_EMPTY;
            end else if (count_q == SK_CW'(1)) begin
              count_q            <= '0;
              out_q.popped_value <= top_val_q;
              out_q.current_min  <= '0;
              out_q.min_valid    <= 1'b0;
              out_q.entry_count  <= '0;
              out_q.error_code   <= ERR_OK;
            end else begin
              count_q   <= count_q - SK_CW'(1);
              pop_val_q <= top_val_q;
              state_q   <= ST_POP;
            end
          end
        end
        ST_POP: begin
          top_val_q <= rd_val;
          top_min_q <= rd_min;
          if (slot_free) begin
            out_q.popped_value <= pop_val_q;
            out_q.current_min  <= rd_min;
            out_q.min_valid    <= 1'b1;
            out_q.entry_count  <= count_q;
            out_q.error_code   <= ERR_OK;
            state_q            <= ST_IDLE;
          end else begin
            state_q <= ST_HOLD;
          end
        end
        ST_HOLD: begin
          if (slot_free) begin
            out_q.popped_value <= pop_val_q;
            out_q.current_min  <= top_min_q;
            out_q.min_valid    <= 1'b1;
            out_q.entry_count  <= count_q;
            out_q.error_code   <= ERR_OK;
            state_q            <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

/* sv/msk_ram.sv */
`timescale 1ns / 1ps

module msk_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
